/* design/tts_pkg.sv */
// Package of the terminal screen updater: sizes, control codes, state and handshake types.
`timescale 1ns / 1ps
package tts_pkg;

    localparam int SCREEN_ROWS = 25;
    localparam int SCREEN_COLS = 80;
    localparam int TAB_STEP    = 8;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

    localparam logic [CHAR_W-1:0] CODE_PAD   = 8'h00;
    localparam logic [CHAR_W-1:0] CODE_BELL  = 8'h07;
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_DOWN  = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_CM    = 8'h10;
    localparam logic [CHAR_W-1:0] CODE_RIGHT = 8'h15;
    localparam logic [CHAR_W-1:0] CODE_CE    = 8'h16;
    localparam logic [CHAR_W-1:0] CODE_CL    = 8'h18;
    localparam logic [CHAR_W-1:0] CODE_UP    = 8'h1A;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ROW,
        PH_COL
    } t_phase;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic sweep_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic need_sweep;
        logic sweep_done;
        logic out_free;
    } t_stat;

endpackage

/* design/tts_ifs.sv */
// Handshake interfaces of the terminal screen updater: request channel and result channel.
`timescale 1ns / 1ps
interface tts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [tts_pkg::CHAR_W-1:0]  data_byte;
    logic [tts_pkg::ROW_W-1:0]   read_row;
    logic [tts_pkg::COL_W-1:0]   read_col;

    modport source (output valid, req_type, data_byte, read_row, read_col, input ready);
    modport sink   (input valid, req_type, data_byte, read_row, read_col, output ready);
endinterface

interface tts_out_if;
    logic                        valid;
    logic                        ready;
    logic [tts_pkg::ROW_W-1:0]   cursor_row;
    logic [tts_pkg::COL_W-1:0]   cursor_col;
    logic                        bell_seen;
    logic                        bad_control;
    logic [tts_pkg::CHAR_W-1:0]  read_char;

    modport source (output valid, cursor_row, cursor_col, bell_seen, bad_control, read_char,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, bell_seen, bad_control, read_char,
                    output ready);
endinterface

/* design/tts_datapath.sv */
// Datapath of the terminal screen updater: cursor, argument phase, character store, result register.
`timescale 1ns / 1ps
module tts_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tts_pkg::t_cmd  i_cmd,
    output tts_pkg::t_stat o_stat,
    tts_in_if.sink         i_in,
    tts_out_if.source      o_out
);
    import tts_pkg::*;

    // Maps a cursor address byte to a position, saturating at limit - 1; bytes below a space map to zero.
    function automatic logic [CHAR_W-1:0] arg_value(input logic [CHAR_W-1:0] b,
                                                    input logic [CHAR_W-1:0] limit);
        logic [CHAR_W-1:0] v;
        v = b - CHAR_SPACE;
        if (b < CHAR_SPACE) begin
            return '0;
        end
        return (v >= limit) ? limit - 8'd1 : v;
    endfunction

    localparam logic [ADDR_W-1:0] A_COLS = ADDR_W'(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] A_LAST = ADDR_W'(DEPTH - 1);

    logic [CHAR_W-1:0] r_store [DEPTH];

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_pend, n_pend;
    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_sweep_addr, r_sweep_last;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_is_read, r_bell, r_bad;
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_o_row;
    logic [COL_W-1:0]  r_o_col;
    logic              r_o_bell, r_o_bad;
    logic [CHAR_W-1:0] r_o_char;

    logic              acc, acc_byte, rd_in_range, rd_en;
    logic              wr_print, set_ce, set_cl, res_bell, res_bad;
    logic              mem_we;
    logic [ADDR_W-1:0] row_base, cur_addr, rd_addr, wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic [COL_W:0]    tab_col;

    assign acc         = i_in.valid & i_cmd.in_ready;
    assign acc_byte    = acc & ~i_in.req_type;
    assign i_in.ready  = i_cmd.in_ready;
    assign row_base    = ADDR_W'(r_row) * A_COLS;
    assign cur_addr    = row_base + ADDR_W'(r_col);
    assign rd_in_range = (int'(i_in.read_row) < SCREEN_ROWS) && (int'(i_in.read_col) < SCREEN_COLS);
    assign rd_addr     = ADDR_W'(i_in.read_row) * A_COLS + ADDR_W'(i_in.read_col);
    assign rd_en       = acc & i_in.req_type & rd_in_range;
    assign tab_col     = (COL_W+1)'((int'(r_col) / TAB_STEP + 1) * TAB_STEP);

    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.need_sweep = ~i_in.req_type && (r_phase == PH_IDLE)
                               && (i_in.data_byte == CODE_CE || i_in.data_byte == CODE_CL);
    assign o_stat.sweep_done = (r_sweep_addr == r_sweep_last);
    assign o_stat.out_free   = ~r_out_valid | o_out.ready;

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_pend   = r_pend;
        n_phase  = r_phase;
        wr_print = 1'b0;
        set_ce   = 1'b0;
        set_cl   = 1'b0;
        res_bell = 1'b0;
        res_bad  = 1'b0;
        if (acc_byte) begin
            unique case (r_phase)
                PH_ROW: begin
                    n_pend  = ROW_W'(arg_value(i_in.data_byte, 8'(SCREEN_ROWS)));
                    n_phase = PH_COL;
                end
                PH_COL: begin
                    n_row   = r_pend;
                    n_col   = COL_W'(arg_value(i_in.data_byte, 8'(SCREEN_COLS)));
                    n_phase = PH_IDLE;
                end
                default: begin
                    unique case (i_in.data_byte)
                        CODE_PAD: ;
                        CODE_BELL: res_bell = 1'b1;
                        CODE_BS: begin
                            if (r_col != '0) n_col = r_col - 1'b1;
                        end
                        CODE_CE: set_ce = 1'b1;
                        CODE_CL: begin
                            set_cl = 1'b1;
                            n_row  = '0;
                            n_col  = '0;
                        end
                        CODE_CM: n_phase = PH_ROW;
                        CODE_CR: n_col = '0;
                        CODE_DOWN: begin
                            if (r_row < ROW_W'(SCREEN_ROWS - 1)) n_row = r_row + 1'b1;
                        end
                        CODE_RIGHT: begin
                            if (r_col < COL_W'(SCREEN_COLS - 1)) n_col = r_col + 1'b1;
                        end
                        CODE_UP: begin
                            if (r_row != '0) n_row = r_row - 1'b1;
                        end
                        CODE_TAB: begin
                            if (int'(tab_col) >= SCREEN_COLS) begin
                                n_col = COL_W'(SCREEN_COLS - 1);
                            end else begin
                                n_col = COL_W'(tab_col);
                            end
                        end
                        default: begin
                            if (i_in.data_byte < CHAR_SPACE || i_in.data_byte > CHAR_LAST) begin
                                res_bad = 1'b1;
                            end else begin
                                wr_print = 1'b1;
                                if (r_col < COL_W'(SCREEN_COLS - 1)) begin
                                    n_col = r_col + 1'b1;
                                end else begin
                                    n_col = '0;
                                    if (r_row < ROW_W'(SCREEN_ROWS - 1)) n_row = r_row + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    assign mem_we  = wr_print | i_cmd.sweep_step;
    assign wr_addr = i_cmd.sweep_step ? r_sweep_addr : cur_addr;
    assign wr_data = i_cmd.sweep_step ? CHAR_SPACE : i_in.data_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= '0;
            r_pend       <= '0;
            r_phase      <= PH_IDLE;
            r_sweep_addr <= '0;
            r_sweep_last <= A_LAST;
            r_out_valid  <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_pend  <= n_pend;
            r_phase <= n_phase;
            if (set_ce) begin
                r_sweep_addr <= cur_addr;
                r_sweep_last <= row_base + A_COLS - 1'b1;
            end else if (set_cl) begin
                r_sweep_addr <= '0;
                r_sweep_last <= A_LAST;
            end else if (i_cmd.sweep_step && !o_stat.sweep_done) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_is_read <= i_in.req_type & rd_in_range;
            r_bell    <= res_bell;
            r_bad     <= res_bad;
        end
        if (i_cmd.load_out) begin
            r_o_row  <= r_row;
            r_o_col  <= r_col;
            r_o_bell <= r_bell;
            r_o_bad  <= r_bad;
            r_o_char <= r_is_read ? r_rd_data : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.cursor_row  = r_o_row;
    assign o_out.cursor_col  = r_o_col;
    assign o_out.bell_seen   = r_o_bell;
    assign o_out.bad_control = r_o_bad;
    assign o_out.read_char   = r_o_char;

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < SCREEN_ROWS && int'(r_col) < SCREEN_COLS && int'(r_pend) < SCREEN_ROWS)
        else $error("cursor or pending row left the screen");

    a_sweep_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep_addr <= r_sweep_last && r_sweep_last <= A_LAST)
        else $error("clear sweep ran past its end");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !i_cmd.in_ready)
        else $error("second item taken before the first finished");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_stat.out_free)
        else $error("result register overwritten while full");

endmodule

/* design/tts_ctrl.sv */
// Controller of the terminal screen updater: sequences acceptance, clear sweeps and result hand-off.
`timescale 1ns / 1ps
module tts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tts_pkg::t_stat i_stat,
    output tts_pkg::t_cmd  o_cmd
);
    import tts_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = i_stat.need_sweep ? ST_SWEEP : ST_RESULT;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_done) n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.in_ready |-> !o_cmd.sweep_step && !o_cmd.load_out)
        else $error("item accepted while the store or result path is busy");

    a_sweep_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && i_stat.sweep_done) |=> r_state == ST_RESULT)
        else $error("clear sweep did not end in a result");

    a_load_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_cmd.in_ready)
        else $error("controller did not return to accept after a result");

endmodule

/* design/text_terminal_screen_updater.sv */
// Top level of the terminal screen updater: joins the controller and the datapath.
//
//   Channel  Direction  Handshake        Payload
//   i_in     in         valid / ready    req_type, data_byte, read_row, read_col
//   o_out    out        valid / ready    cursor_row, cursor_col, bell_seen, bad_control, read_char
//
// An ordinary item is accepted in ST_IDLE, where the cursor is updated or the store read,
// and its result is moved into the output register in ST_RESULT.
// Clear to end of line blanks SCREEN_COLS - column cells and clear screen blanks all
// SCREEN_ROWS * SCREEN_COLS cells in ST_SWEEP; the store's single write port blanks
// one cell a cycle.
// After reset the store is blanked the same way, all 2000 cells, before ready rises.
// A full output register stalls the hand-off in ST_RESULT; no next item is accepted meanwhile.
`timescale 1ns / 1ps
module text_terminal_screen_updater (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tts_in_if.sink     i_in,
    tts_out_if.source  o_out
);
    import tts_pkg::*;

    // Commands from the controller and status back from the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller decides when an item is taken, when the store sweep runs and
    // when the finished result may be loaded into the output register.
    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the cursor, the pending cursor-address argument, the
    // character store and the output register.
    tts_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench of the terminal screen updater: byte stream, cursor and cell reads.
`timescale 1ns / 1ps
module testbench;
    import tts_pkg::*;

    // One request as the input channel carries it.
    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] data_byte;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_request;

    // One cursor report as the output channel carries it.
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              bell_seen;
        logic              bad_control;
        logic [CHAR_W-1:0] read_char;
    } t_report;

    localparam int DIRECT_ITEMS = 30;
    localparam int RANDOM_ITEMS = 1100;
    // Items inside this window go through with no idling on either side.
    localparam int STEADY_FROM  = 200;
    localparam int STEADY_TO    = 350;
    // After this many results the receiver holds off long enough to back the block up.
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 36;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tts_in_if  in_if ();
    tts_out_if out_if ();

    text_terminal_screen_updater i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the screen and the cursor, kept in step with accepted items.
    logic [CHAR_W-1:0] screen_copy [0:DEPTH-1];
    int                cur_row;
    int                cur_col;
    int                addr_row;
    t_phase            addr_phase;

    t_request requests_to_send [$];
    t_report  cursor_reports_due [$];

    int n_sent;
    int n_recv;
    int n_errors;
    int hold_left;
    bit hold_done;

    // What the run went through, for the summary at the end.
    int n_printed;
    int n_moves;
    int n_reads;
    int n_screen_clears;
    int n_line_clears;
    int n_bad;
    int n_bells;

    // An address byte carries its value offset by a space; short values give zero and
    // values past the screen stop at the last row or column.
    function automatic int addr_arg(logic [CHAR_W-1:0] b, int lim);
        int v;
        if (b < CHAR_SPACE) begin
            return 0;
        end
        v = int'(b) - int'(CHAR_SPACE);
        return (v >= lim) ? lim - 1 : v;
    endfunction

    // Applies one accepted item to the shadow screen and returns the report it must cause.
    function automatic t_report apply_to_screen(t_request rq);
        t_report rp;
        int      i;
        rp = '0;
        if (rq.req_type == 1'b0) begin
            if (addr_phase == PH_ROW) begin
                addr_row   = addr_arg(rq.data_byte, SCREEN_ROWS);
                addr_phase = PH_COL;
            end else if (addr_phase == PH_COL) begin
                cur_row    = addr_row;
                cur_col    = addr_arg(rq.data_byte, SCREEN_COLS);
                addr_phase = PH_IDLE;
                n_moves++;
            end else begin
                case (rq.data_byte)
                    CODE_PAD: begin
                    end
                    CODE_BELL: begin
                        rp.bell_seen = 1'b1;
                        n_bells++;
                    end
                    CODE_BS: begin
                        if (cur_col > 0) cur_col--;
                    end
                    CODE_CE: begin
                        for (i = cur_col; i < SCREEN_COLS; i++)
                            screen_copy[cur_row * SCREEN_COLS + i] = CHAR_SPACE;
                        n_line_clears++;
                    end
                    CODE_CL: begin
                        for (i = 0; i < DEPTH; i++) screen_copy[i] = CHAR_SPACE;
                        cur_row = 0;
                        cur_col = 0;
                        n_screen_clears++;
                    end
                    CODE_CM: begin
                        addr_phase = PH_ROW;
                    end
                    CODE_CR: begin
                        cur_col = 0;
                    end
                    CODE_DOWN: begin
                        if (cur_row + 1 < SCREEN_ROWS) cur_row++;
                    end
                    CODE_RIGHT: begin
                        if (cur_col + 1 < SCREEN_COLS) cur_col++;
                    end
                    CODE_UP: begin
                        if (cur_row > 0) cur_row--;
                    end
                    CODE_TAB: begin
                        cur_col = TAB_STEP * (1 + cur_col / TAB_STEP);
                        if (cur_col >= SCREEN_COLS) cur_col = SCREEN_COLS - 1;
                    end
                    default: begin
                        if (rq.data_byte < CHAR_SPACE || rq.data_byte > CHAR_LAST) begin
                            rp.bad_control = 1'b1;
                            n_bad++;
                        end else begin
                            // Printing in the last column wraps to the next row, except on
                            // the last row, where the row stays put.
                            screen_copy[cur_row * SCREEN_COLS + cur_col] = rq.data_byte;
                            cur_col++;
                            if (cur_col >= SCREEN_COLS) begin
                                cur_col = 0;
                                if (cur_row + 1 < SCREEN_ROWS) cur_row++;
                            end
                            n_printed++;
                        end
                    end
                endcase
            end
        end else begin
            // A read leaves the address phase alone; cells off the screen read as zero.
            if (rq.read_row < SCREEN_ROWS && rq.read_col < SCREEN_COLS)
                rp.read_char = screen_copy[rq.read_row * SCREEN_COLS + rq.read_col];
            n_reads++;
        end
        rp.cursor_row = cur_row[ROW_W-1:0];
        rp.cursor_col = cur_col[COL_W-1:0];
        return rp;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
                     n_recv, what, got, want);
    endtask

    // Stream byte; the read fields are noise that the block must ignore.
    task automatic queue_byte(logic [CHAR_W-1:0] b);
        t_request rq;
        rq.req_type  = 1'b0;
        rq.data_byte = b;
        rq.read_row  = ROW_W'($urandom_range(0, 31));
        rq.read_col  = COL_W'($urandom_range(0, 127));
        requests_to_send.push_back(rq);
    endtask

    // Cell read; the stream byte is noise.
    task automatic queue_read(int r, int c);
        t_request rq;
        rq.req_type  = 1'b1;
        rq.data_byte = CHAR_W'($urandom_range(0, 255));
        rq.read_row  = ROW_W'(r);
        rq.read_col  = COL_W'(c);
        requests_to_send.push_back(rq);
    endtask

    // Address argument: mostly on the screen, some past it, some any byte at all.
    function automatic logic [CHAR_W-1:0] pick_arg(int lim);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return CHAR_W'(int'(CHAR_SPACE) + $urandom_range(0, lim - 1));
        if (sel < 85) return CHAR_W'(int'(CHAR_SPACE) + lim - 1);
        if (sel < 92) return CHAR_W'(int'(CHAR_SPACE) + $urandom_range(lim, 'hDF));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_unknown_code();
        logic [CHAR_W-1:0] b;
        do begin
            b = CHAR_W'($urandom_range(1, 31));
        end while (b == CODE_BELL || b == CODE_BS || b == CODE_TAB || b == CODE_DOWN ||
                   b == CODE_CR || b == CODE_CM || b == CODE_RIGHT || b == CODE_CE ||
                   b == CODE_CL || b == CODE_UP);
        return b;
    endfunction

    // Driver: offers queued requests, idles at random, and predicts on every acceptance.
    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                rq.req_type  = in_if.req_type;
                rq.data_byte = in_if.data_byte;
                rq.read_row  = in_if.read_row;
                rq.read_col  = in_if.read_col;
                cursor_reports_due.push_back(apply_to_screen(rq));
                n_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (requests_to_send.size() != 0 &&
                    ((n_sent >= STEADY_FROM && n_sent < STEADY_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    rq = requests_to_send.pop_front();
                    in_if.req_type  <= rq.req_type;
                    in_if.data_byte <= rq.data_byte;
                    in_if.read_row  <= rq.read_row;
                    in_if.read_col  <= rq.read_col;
                    in_if.valid     <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only has to look at it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_recv >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: checks each accepted report against the oldest one due, field by field.
    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (cursor_reports_due.size() == 0) begin
                    report_mismatch("result with nothing due, cursor_col",
                                    out_if.cursor_col, 0);
                end else begin
                    want = cursor_reports_due.pop_front();
                    if (out_if.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", out_if.cursor_row, want.cursor_row);
                    if (out_if.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", out_if.cursor_col, want.cursor_col);
                    if (out_if.bell_seen !== want.bell_seen)
                        report_mismatch("bell_seen", out_if.bell_seen, want.bell_seen);
                    if (out_if.bad_control !== want.bad_control)
                        report_mismatch("bad_control", out_if.bad_control, want.bad_control);
                    if (out_if.read_char !== want.read_char)
                        report_mismatch("read_char", out_if.read_char, want.read_char);
                end
                n_recv++;
            end
            out_if.ready <= (hold_left == 0) &&
                            ((n_recv >= STEADY_FROM && n_recv < STEADY_TO) ||
                             $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus and end of run.
    initial begin
        int i;
        int sel;
        int len;
        int k;
        in_if.valid     = 1'b0;
        in_if.req_type  = 1'b0;
        in_if.data_byte = '0;
        in_if.read_row  = '0;
        in_if.read_col  = '0;
        out_if.ready    = 1'b0;

        for (i = 0; i < DEPTH; i++) screen_copy[i] = CHAR_SPACE;
        cur_row    = 0;
        cur_col    = 0;
        addr_row   = 0;
        addr_phase = PH_IDLE;

        // Directed opening: saturation at every edge, each code, both kinds of bad byte,
        // wrap on the last row, a read between address bytes and reads off the screen.
        queue_read(0, 0);
        queue_byte(CODE_BS);
        queue_byte(CODE_UP);
        queue_byte(CODE_PAD);
        queue_byte(CODE_BELL);
        queue_byte(8'h41);
        queue_byte(CHAR_LAST);
        queue_byte(8'h80);
        queue_byte(8'h01);
        queue_byte(CODE_TAB);
        queue_byte(CODE_RIGHT);
        queue_byte(CODE_CR);
        queue_byte(CODE_DOWN);
        queue_byte(CODE_CM);
        queue_byte(8'h05);
        queue_read(0, 1);
        queue_byte(8'hFF);
        queue_byte(CODE_RIGHT);
        queue_byte(CODE_TAB);
        queue_byte(CODE_CE);
        queue_byte(8'h5A);
        queue_byte(CODE_CM);
        queue_byte(8'hFF);
        queue_byte(8'h6F);
        queue_byte(8'h5A);
        queue_byte(CODE_DOWN);
        queue_read(SCREEN_ROWS - 1, SCREEN_COLS - 1);
        queue_read(31, 127);
        queue_read(SCREEN_ROWS - 1, SCREEN_COLS);
        queue_byte(CODE_CL);

        // Random part: mostly text and well-formed cursor addresses, some noise.
        while (requests_to_send.size() < DIRECT_ITEMS + RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 38) begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    queue_byte(CHAR_W'($urandom_range(int'(CHAR_SPACE), int'(CHAR_LAST))));
            end else if (sel < 54) begin
                case ($urandom_range(0, 8))
                    0: queue_byte(CODE_PAD);
                    1: queue_byte(CODE_BELL);
                    2: queue_byte(CODE_BS);
                    3: queue_byte(CODE_TAB);
                    4: queue_byte(CODE_DOWN);
                    5: queue_byte(CODE_CR);
                    6: queue_byte(CODE_RIGHT);
                    7: queue_byte(CODE_UP);
                    default: queue_byte(CODE_CE);
                endcase
            end else if (sel < 68) begin
                queue_byte(CODE_CM);
                queue_byte(pick_arg(SCREEN_ROWS));
                if ($urandom_range(0, 9) == 0)
                    queue_read($urandom_range(0, SCREEN_ROWS - 1),
                               $urandom_range(0, SCREEN_COLS - 1));
                queue_byte(pick_arg(SCREEN_COLS));
            end else if (sel < 88) begin
                if ($urandom_range(0, 9) < 8)
                    queue_read($urandom_range(0, SCREEN_ROWS - 1),
                               $urandom_range(0, SCREEN_COLS - 1));
                else
                    queue_read($urandom_range(0, 31), $urandom_range(0, 127));
            end else if (sel < 93) begin
                if ($urandom_range(0, 1) == 0)
                    queue_byte(CHAR_W'($urandom_range(8'h80, 8'hFF)));
                else
                    queue_byte(pick_unknown_code());
            end else if (sel < 94) begin
                queue_byte(CODE_CL);
            end else begin
                queue_byte(CODE_CR);
                queue_byte(CODE_DOWN);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled at the falling edge so the driver's updates of this cycle are settled.
        do @(negedge i_clk); while (requests_to_send.size() != 0 || in_if.valid);
        do @(negedge i_clk); while (cursor_reports_due.size() != 0);
        repeat (50) @(negedge i_clk);

        $display("run covered %0d items: %0d printed cells, %0d cursor addresses, %0d reads",
                 n_sent, n_printed, n_moves, n_reads);
        $display("also %0d screen clears, %0d line clears, %0d bad bytes, %0d bells",
                 n_screen_clears, n_line_clears, n_bad, n_bells);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Watchdog, well past the slowest correct run including the blanking after reset.
    initial begin
        #4_000_000;
        $display("timeout with %0d results still due", cursor_reports_due.size());
        $display("testbench: errors");
        $finish;
    end

endmodule
